// File: sv/double_ended_queue_with_key_removal_unit_defines.svh
// assertion macros for the double-ended queue checker
// needs clk and rst_n in the scope where a macro is used
`ifndef DOUBLE_ENDED_QUEUE_WITH_KEY_REMOVAL_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_WITH_KEY_REMOVAL_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define DQKR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DQKR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dqkr_pkg.sv
// shared types and constants of the double-ended queue with key removal
// no dependencies
package dqkr_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int ID_W      = 16;
  localparam int TIME_W    = 16;
  localparam int WORD_W    = ID_W + TIME_W;
  localparam int COUNT_W   = 5;

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_REMOVE_KEY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NOKEY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DEQ,
    S_SCAN,
    S_SHIFT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    load;
    logic    push_back;
    logic    push_front;
    logic    deq_rd;
    logic    deq_take;
    logic    scan_init;
    logic    scan_step;
    logic    shift_step;
    logic    count_dec;
    logic    finish;
    status_t fin_status;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic hit;
    logic miss_done;
    logic shift_done;
  } stat_t;

endpackage

// File: sv/dqkr_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module dqkr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/dqkr_ctrl.sv
// controller state machine of the double-ended queue
// depends on dqkr_pkg
module dqkr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  dqkr_pkg::stat_t stat,
  output dqkr_pkg::cmd_t  cmd
);

  dqkr_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dqkr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.fin_status = dqkr_pkg::ST_OK;
    busy      = 1'b1;
    unique case (state_r)
      dqkr_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = dqkr_pkg::S_EXEC;
        end
      end
      dqkr_pkg::S_EXEC: begin
        unique case (stat.op)
          dqkr_pkg::OP_PUSH_BACK, dqkr_pkg::OP_PUSH_FRONT: begin
            cmd.finish = 1'b1;
            state_nxt  = dqkr_pkg::S_IDLE;
            if (stat.full) begin
              cmd.fin_status = dqkr_pkg::ST_FULL;
            end else if (stat.op == dqkr_pkg::OP_PUSH_BACK) begin
              cmd.push_back = 1'b1;
            end else begin
              cmd.push_front = 1'b1;
            end
          end
          dqkr_pkg::OP_POP_FRONT: begin
            if (stat.empty) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = dqkr_pkg::ST_EMPTY;
              state_nxt      = dqkr_pkg::S_IDLE;
            end else begin
              cmd.deq_rd = 1'b1;
              state_nxt  = dqkr_pkg::S_DEQ;
            end
          end
          dqkr_pkg::OP_REMOVE_KEY: begin
            if (stat.empty) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = dqkr_pkg::ST_EMPTY;
              state_nxt      = dqkr_pkg::S_IDLE;
            end else begin
              cmd.scan_init = 1'b1;
              state_nxt     = dqkr_pkg::S_SCAN;
            end
          end
          default: begin
            state_nxt = dqkr_pkg::S_IDLE;
          end
        endcase
      end
      dqkr_pkg::S_DEQ: begin
        cmd.deq_take = 1'b1;
        cmd.finish   = 1'b1;
        state_nxt    = dqkr_pkg::S_IDLE;
      end
      dqkr_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.hit) begin
          state_nxt = dqkr_pkg::S_SHIFT;
        end else if (stat.miss_done) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = dqkr_pkg::ST_NOKEY;
          state_nxt      = dqkr_pkg::S_IDLE;
        end
      end
      dqkr_pkg::S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (stat.shift_done) begin
          cmd.count_dec = 1'b1;
          cmd.finish    = 1'b1;
          state_nxt     = dqkr_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dqkr_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/dqkr_dp.sv
// datapath of the double-ended queue: entry ram, pointers, scan and shift
// depends on dqkr_pkg and dqkr_ram
module dqkr_dp #(
  parameter int DEPTH = dqkr_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   in_op,
  input  logic [dqkr_pkg::ID_W-1:0]    in_item_id,
  input  logic [dqkr_pkg::TIME_W-1:0]  in_time_units,
  input  dqkr_pkg::cmd_t               cmd,
  output dqkr_pkg::stat_t              stat,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [dqkr_pkg::ID_W-1:0]    out_id,
  output logic [dqkr_pkg::TIME_W-1:0]  out_time,
  output logic [dqkr_pkg::COUNT_W-1:0] out_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int IW = dqkr_pkg::ID_W;
  localparam int TW = dqkr_pkg::TIME_W;
  localparam int WW = dqkr_pkg::WORD_W;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  // slot of the entry at a logical position, counted from the front
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                           input logic [CW-1:0] pos);
    logic [SW-1:0] s;
    s = SW'(front) + SW'(pos);
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[AW-1:0];
  endfunction

  dqkr_pkg::op_t                  op_r, op_nxt;
  logic [IW-1:0]                  id_r, id_nxt;
  logic [TW-1:0]                  key_r, key_nxt;
  logic [AW-1:0]                  front_r, front_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [CW-1:0]                  idx_r, idx_nxt;
  logic [CW-1:0]                  pidx_r, pidx_nxt;
  logic                           pend_r, pend_nxt;
  logic [IW-1:0]                  rid_r, rid_nxt;
  logic [TW-1:0]                  rtm_r, rtm_nxt;
  logic                           valid_r, valid_nxt;
  dqkr_pkg::status_t              status_r, status_nxt;
  logic [dqkr_pkg::COUNT_W-1:0]   ocnt_r, ocnt_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [WW-1:0] wdata, rdata;
  logic          hit, issue_scan, issue_shift;

  dqkr_ram #(
    .WIDTH (WW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // compare of the entry read last cycle with the key
  assign hit         = pend_r && (rdata[TW-1:0] == key_r);
  assign issue_scan  = (idx_r != '0);
  assign issue_shift = (idx_r < count_r);

  assign stat.op         = op_r;
  assign stat.full       = (count_r == DEPTH_C);
  assign stat.empty      = (count_r == '0);
  assign stat.hit        = hit;
  assign stat.miss_done  = pend_r && !hit && !issue_scan;
  assign stat.shift_done = !issue_shift && !pend_r;

  // datapath next values
  always_comb begin
    op_nxt     = op_r;
    id_nxt     = id_r;
    key_nxt    = key_r;
    front_nxt  = front_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    pidx_nxt   = pidx_r;
    pend_nxt   = pend_r;
    rid_nxt    = rid_r;
    rtm_nxt    = rtm_r;
    valid_nxt  = 1'b0;
    status_nxt = status_r;
    ocnt_nxt   = ocnt_r;
    we         = 1'b0;
    waddr      = front_r;
    wdata      = {id_r, key_r};
    raddr      = front_r;

    // capture the request
    if (cmd.load) begin
      op_nxt  = dqkr_pkg::op_t'(in_op);
      id_nxt  = in_item_id;
      key_nxt = in_time_units;
      rid_nxt = '0;
      rtm_nxt = '0;
    end

    // enqueue at the back
    if (cmd.push_back) begin
      we        = 1'b1;
      waddr     = slot_of(front_r, count_r);
      count_nxt = count_r + 1'b1;
    end

    // enqueue at the front
    if (cmd.push_front) begin
      front_nxt = (front_r == '0) ? LAST_A : front_r - 1'b1;
      we        = 1'b1;
      waddr     = front_nxt;
      count_nxt = count_r + 1'b1;
    end

    // dequeue: read the front slot, then take it
    if (cmd.deq_rd) begin
      raddr = front_r;
    end
    if (cmd.deq_take) begin
      rid_nxt   = rdata[WW-1:TW];
      rtm_nxt   = rdata[TW-1:0];
      front_nxt = slot_of(front_r, CW'(1));
      count_nxt = count_r - 1'b1;
    end

    // key search from the back of the queue, one read per cycle
    if (cmd.scan_init) begin
      idx_nxt  = count_r;
      pend_nxt = 1'b0;
    end
    if (cmd.scan_step) begin
      raddr    = slot_of(front_r, idx_r - 1'b1);
      pend_nxt = issue_scan;
      pidx_nxt = idx_r - 1'b1;
      if (issue_scan) begin
        idx_nxt = idx_r - 1'b1;
      end
      if (hit) begin
        rid_nxt  = rdata[WW-1:TW];
        rtm_nxt  = rdata[TW-1:0];
        idx_nxt  = pidx_r + 1'b1;
        pend_nxt = 1'b0;
      end
    end

    // close the gap: read position p, write it back at p-1 next cycle
    if (cmd.shift_step) begin
      raddr    = slot_of(front_r, idx_r);
      pend_nxt = issue_shift;
      pidx_nxt = idx_r - 1'b1;
      if (issue_shift) begin
        idx_nxt = idx_r + 1'b1;
      end
      if (pend_r) begin
        we    = 1'b1;
        waddr = slot_of(front_r, pidx_r);
        wdata = rdata;
      end
    end

    if (cmd.count_dec) begin
      count_nxt = count_r - 1'b1;
    end

    // result register
    if (cmd.finish) begin
      valid_nxt  = 1'b1;
      status_nxt = cmd.fin_status;
      ocnt_nxt   = dqkr_pkg::COUNT_W'(count_nxt);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
      pend_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      valid_r <= valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    id_r     <= id_nxt;
    key_r    <= key_nxt;
    idx_r    <= idx_nxt;
    pidx_r   <= pidx_nxt;
    rid_r    <= rid_nxt;
    rtm_r    <= rtm_nxt;
    status_r <= status_nxt;
    ocnt_r   <= ocnt_nxt;
  end

  assign out_valid  = valid_r;
  assign out_status = status_r;
  assign out_id     = rid_r;
  assign out_time   = rtm_r;
  assign out_count  = ocnt_r;

endmodule

// File: sv/double_ended_queue_with_key_removal_unit.sv
// top level of the double-ended queue with key removal
// depends on dqkr_pkg, dqkr_ctrl, dqkr_dp (and dqkr_ram below it)
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. in_op
//   selects push back (0), push front (1), pop front (2) or remove by time key
//   (3); in_item_id and in_time_units carry the entry or the search key.
//   Every request gives exactly one result: out_valid is high for one cycle
//   with out_status, out_id, out_time and out_count. The receiver cannot
//   stall; the result must be taken in that cycle.
//   A push, or any request that fails on full or empty, finishes in S_EXEC; a
//   pop reads the front slot in S_EXEC and takes it in S_DEQ.
//   Remove by key reads one entry per cycle from the back end through the
//   single read port of the entry ram, then moves each entry behind the hit one
//   slot down, one per cycle.
//   busy stays high until the result is registered; a new request can be
//   taken in the cycle in which the previous result is shown.
//   Reset empties the queue (count and front pointer to zero); the entry ram
//   is not cleared and needs no clearing pass.
module double_ended_queue_with_key_removal_unit #(
  parameter int DEPTH = dqkr_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_op,
  input  logic [dqkr_pkg::ID_W-1:0]    in_item_id,
  input  logic [dqkr_pkg::TIME_W-1:0]  in_time_units,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [dqkr_pkg::ID_W-1:0]    out_id,
  output logic [dqkr_pkg::TIME_W-1:0]  out_time,
  output logic [dqkr_pkg::COUNT_W-1:0] out_count
);

  dqkr_pkg::cmd_t  cmd;
  dqkr_pkg::stat_t stat;

  // controller
  dqkr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // datapath
  dqkr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_op         (in_op),
    .in_item_id    (in_item_id),
    .in_time_units (in_time_units),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_id        (out_id),
    .out_time      (out_time),
    .out_count     (out_count)
  );

endmodule

// File: sv/dqkr_chk.sv
// port-level checker for the double-ended queue, bound to the top level
// depends on dqkr_pkg and the assertion macro header
`include "double_ended_queue_with_key_removal_unit_defines.svh"

module dqkr_chk #(
  parameter int DEPTH = dqkr_pkg::DEPTH_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic [1:0]                   out_status,
  input logic [dqkr_pkg::ID_W-1:0]    out_id,
  input logic [dqkr_pkg::TIME_W-1:0]  out_time,
  input logic [dqkr_pkg::COUNT_W-1:0] out_count
);

  localparam logic [dqkr_pkg::COUNT_W-1:0] FULL_CNT = dqkr_pkg::COUNT_W'(DEPTH);

  // a taken request keeps the block busy in the next cycle
  `DQKR_ASSERT_NEXT(a_busy_after_req, start && !busy, busy, "busy low after request")

  // results are single-cycle strobes, never back to back
  `DQKR_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "out_valid held two cycles")

  // failed requests return no entry
  `DQKR_ASSERT_NOW(a_fail_zero, out_valid && (out_status != dqkr_pkg::ST_OK), (out_id == '0) && (out_time == '0), "entry data on failed request")

  // empty status reports an empty queue
  `DQKR_ASSERT_NOW(a_empty_cnt, out_valid && (out_status == dqkr_pkg::ST_EMPTY), out_count == '0, "empty status with nonzero count")

  // full status reports a full queue
  `DQKR_ASSERT_NOW(a_full_cnt, out_valid && (out_status == dqkr_pkg::ST_FULL), out_count == FULL_CNT, "full status with wrong count")

endmodule

bind double_ended_queue_with_key_removal_unit dqkr_chk #(
  .DEPTH (DEPTH)
) u_dqkr_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_status    (out_status),
  .out_id        (out_id),
  .out_time      (out_time),
  .out_count     (out_count)
);
